FILE: rtl/sglms_pkg.sv
package sglms_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_SPAN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_MODE = 2'd1;

	localparam logic [2:0] HALF_SPAN_RST = 3'd7;
	localparam logic       GRID_MODE_RST = 1'b1;

	// Stream payload widths
	localparam int IN_W        = 32;
	localparam int OUT_INDEX_W = 8;
	localparam int OUT_SCORE_W = 32;
	localparam int OUT_DATA_W  = OUT_INDEX_W + OUT_SCORE_W;

	// Neighbour walk: step 0 is the center, then one step per neighbour
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] GRID_LAST_STEP = 4'd8;
	localparam logic [STEP_W-1:0] LINE_LAST_STEP = 4'd2;

	// Controller -> datapath
	typedef struct packed {
		logic load_wr;     // store the accepted score
		logic pass_start;  // clear walk counters and peak count
		logic pass_issue;  // read one (entry, neighbour) pair
		logic sort_start;  // clear sort and output pointers
		logic sort_load;   // read entry i of the peak list
		logic sort_scan;   // read entry j of the peak list
		logic swap_a;      // write best into slot i
		logic swap_b;      // write old slot i into best slot
		logic out_read;    // read next result from the peak list
		logic out_load;    // load output register from peak list
		logic out_empty;   // load output register with the empty marker
		logic out_next;    // advance output pointer
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic load_last;   // next score completes the grid
		logic pass_last;   // walk is at its final step
		logic peak_none;   // no maxima found
		logic sort_more;   // sort position i still has a tail
		logic scan_last;   // scan is at the last list entry
		logic out_final;   // output register holds the final result
	} sts_t;

endpackage

FILE: rtl/sglms_ram.sv
module sglms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/sglms_ctrl.sv
module sglms_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            out_ready,
	output logic            out_valid,
	input  sglms_pkg::sts_t sts,
	output sglms_pkg::cmd_t cmd
);

	typedef enum logic [11:0] {
		ST_LOAD       = 12'b0000_0000_0001,
		ST_PASS       = 12'b0000_0000_0010,
		ST_DRAIN      = 12'b0000_0000_0100,
		ST_SORT_CHECK = 12'b0000_0000_1000,
		ST_LOAD_I     = 12'b0000_0001_0000,
		ST_SCAN       = 12'b0000_0010_0000,
		ST_SCAN_END   = 12'b0000_0100_0000,
		ST_SWAP_A     = 12'b0000_1000_0000,
		ST_SWAP_B     = 12'b0001_0000_0000,
		ST_OUT_RD     = 12'b0010_0000_0000,
		ST_OUT_LD     = 12'b0100_0000_0000,
		ST_OUT_WAIT   = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready    = 1'b1;
				cmd.load_wr = in_valid;
				if (in_valid && sts.load_last) begin
					cmd.pass_start = 1'b1;
					state_d        = ST_PASS;
				end
			end
			ST_PASS: begin
				cmd.pass_issue = 1'b1;
				if (sts.pass_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last compare lands this cycle
				cmd.sort_start = 1'b1;
				state_d        = ST_SORT_CHECK;
			end
			ST_SORT_CHECK: begin
				if (sts.peak_none) begin
					cmd.out_empty = 1'b1;
					state_d       = ST_OUT_WAIT;
				end else if (sts.sort_more) begin
					state_d = ST_LOAD_I;
				end else begin
					state_d = ST_OUT_RD;
				end
			end
			ST_LOAD_I: begin
				cmd.sort_load = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.sort_scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_SWAP_A;
			end
			ST_SWAP_A: begin
				cmd.swap_a = 1'b1;
				state_d    = ST_SWAP_B;
			end
			ST_SWAP_B: begin
				cmd.swap_b = 1'b1;
				state_d    = ST_SORT_CHECK;
			end
			ST_OUT_RD: begin
				in_ready     = !sts.load_last;
				cmd.load_wr  = in_valid && !sts.load_last;
				cmd.out_read = 1'b1;
				state_d      = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				in_ready     = !sts.load_last;
				cmd.load_wr  = in_valid && !sts.load_last;
				cmd.out_load = 1'b1;
				state_d      = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				in_ready    = !sts.load_last;
				cmd.load_wr = in_valid && !sts.load_last;
				out_valid   = 1'b1;
				if (out_ready) begin
					if (sts.out_final) begin
						state_d = ST_LOAD;
					end else begin
						cmd.out_next = 1'b1;
						state_d      = ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/sglms_dp.sv
module sglms_dp #(
	parameter int MAX_HALF_SPAN = 7,
	parameter int SCORE_BITS    = 32,
	parameter int MAX_PEAKS     = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sglms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sglms_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [sglms_pkg::IN_W-1:0]           in_score,
	input  sglms_pkg::cmd_t                      cmd,
	output sglms_pkg::sts_t                      sts,
	output logic [sglms_pkg::OUT_INDEX_W-1:0]    out_index,
	output logic [sglms_pkg::OUT_SCORE_W-1:0]    out_score,
	output logic                                 out_none,
	output logic                                 out_final
);

	localparam int SIDE_MAX    = 2 * MAX_HALF_SPAN + 1;
	localparam int STORE_DEPTH = SIDE_MAX * SIDE_MAX;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int HS_W        = $clog2(MAX_HALF_SPAN + 1);
	localparam int SIDE_W      = HS_W + 1;
	localparam int NB_W        = IDX_W + 2;
	localparam int PA_W        = $clog2(MAX_PEAKS);
	localparam int PK_W        = $clog2(MAX_PEAKS + 1);
	localparam int PE_W        = IDX_W + SCORE_BITS;
	localparam logic [HS_W+2:0] HS_CAP = (HS_W + 3)'(MAX_HALF_SPAN);
	localparam logic signed [NB_W-1:0] ONE_S = NB_W'(1);

	// ---------------- configuration ----------------
	logic [2:0] half_span_q;
	logic       grid_mode_q;
	logic       cfg_hit;

	assign cfg_hit = cfg_we &&
		(cfg_index == sglms_pkg::REG_HALF_SPAN || cfg_index == sglms_pkg::REG_GRID_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_span_q <= sglms_pkg::HALF_SPAN_RST;
			grid_mode_q <= sglms_pkg::GRID_MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sglms_pkg::REG_HALF_SPAN: half_span_q <= cfg_data;
				sglms_pkg::REG_GRID_MODE: grid_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// grid geometry
	logic [HS_W+2:0]     hs_wide;
	logic [HS_W-1:0]     hs_eff;
	logic [SIDE_W-1:0]   side;
	logic [2*SIDE_W-1:0] side_sq;
	logic [IDX_W-1:0]    total;
	logic [IDX_W-1:0]    total_m1;

	assign hs_wide  = (HS_W + 3)'(half_span_q);
	assign hs_eff   = (hs_wide > HS_CAP) ? HS_W'(MAX_HALF_SPAN) : HS_W'(half_span_q);
	assign side     = {hs_eff, 1'b1};
	assign side_sq  = side * side;
	assign total    = grid_mode_q ? IDX_W'(side_sq) : IDX_W'(side);
	assign total_m1 = total - IDX_W'(1);

	// ---------------- load ----------------
	logic [IDX_W-1:0] load_cnt_q;

	assign sts.load_last = (load_cnt_q == total_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (cfg_hit) begin
			load_cnt_q <= '0;
		end else if (cmd.load_wr) begin
			load_cnt_q <= sts.load_last ? '0 : load_cnt_q + IDX_W'(1);
		end
	end

	// ---------------- neighbour walk ----------------
	logic [IDX_W-1:0]          entry_q;
	logic [sglms_pkg::STEP_W-1:0] step_q;
	logic [sglms_pkg::STEP_W-1:0] last_step;
	logic signed [NB_W-1:0]    side_s;
	logic signed [NB_W-1:0]    off;
	logic signed [NB_W-1:0]    nb;
	logic                      nb_in;
	logic                      step_end;

	assign last_step = grid_mode_q ? sglms_pkg::GRID_LAST_STEP : sglms_pkg::LINE_LAST_STEP;
	assign side_s    = $signed(NB_W'(side));
	assign step_end  = (step_q == last_step);
	assign sts.pass_last = step_end && (entry_q == total_m1);

	// linear offsets; row edges wrap
	always_comb begin
		off = '0;
		if (grid_mode_q) begin
			case (step_q)
				4'd1:    off = -side_s - ONE_S;
				4'd2:    off = -side_s;
				4'd3:    off = -side_s + ONE_S;
				4'd4:    off = -ONE_S;
				4'd5:    off = ONE_S;
				4'd6:    off = side_s - ONE_S;
				4'd7:    off = side_s;
				4'd8:    off = side_s + ONE_S;
				default: off = '0;
			endcase
		end else begin
			case (step_q)
				4'd1:    off = -ONE_S;
				4'd2:    off = ONE_S;
				default: off = '0;
			endcase
		end
	end

	assign nb    = $signed({2'b00, entry_q}) + off;
	assign nb_in = !nb[NB_W-1] && (nb < $signed({2'b00, total}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			step_q  <= '0;
		end else if (cmd.pass_start) begin
			entry_q <= '0;
			step_q  <= '0;
		end else if (cmd.pass_issue) begin
			if (step_end) begin
				step_q  <= '0;
				entry_q <= entry_q + IDX_W'(1);
			end else begin
				step_q <= step_q + sglms_pkg::STEP_W'(1);
			end
		end
	end

	// score store
	logic [SCORE_BITS-1:0] sc_rd;

	sglms_ram #(
		.WIDTH (SCORE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_score_ram (
		.clk     (clk),
		.wr_en   (cmd.load_wr),
		.wr_addr (load_cnt_q),
		.wr_data (SCORE_BITS'($signed(in_score))),
		.rd_en   (cmd.pass_issue && nb_in),
		.rd_addr (nb[IDX_W-1:0]),
		.rd_data (sc_rd)
	);

	// tag travels alongside the read
	logic             p_vld_s1;
	logic             p_ctr_s1;
	logic             p_last_s1;
	logic             p_in_s1;
	logic [IDX_W-1:0] p_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_vld_s1 <= 1'b0;
		end else begin
			p_vld_s1 <= cmd.pass_issue;
		end
	end

	always_ff @(posedge clk) begin
		p_ctr_s1  <= (step_q == '0);
		p_last_s1 <= step_end;
		p_in_s1   <= nb_in;
		p_idx_s1  <= entry_q;
	end

	logic signed [SCORE_BITS-1:0] here_q;
	logic                         keep_q;
	logic                         suppress;
	logic                         keep_n;
	logic                         pk_keep;
	logic [PK_W-1:0]              count_q;

	// equal neighbour suppresses too
	assign suppress = p_in_s1 && ($signed(sc_rd) >= here_q);
	assign keep_n   = keep_q && !suppress;
	assign pk_keep  = p_vld_s1 && !p_ctr_s1 && p_last_s1 && keep_n &&
		(count_q < PK_W'(MAX_PEAKS));

	always_ff @(posedge clk) begin
		if (p_vld_s1) begin
			if (p_ctr_s1) begin
				here_q <= $signed(sc_rd);
				keep_q <= 1'b1;
			end else begin
				keep_q <= keep_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.pass_start) begin
			count_q <= '0;
		end else if (pk_keep) begin
			count_q <= count_q + PK_W'(1);
		end
	end

	// ---------------- peak list and selection sort ----------------
	logic [PA_W-1:0] si_q;
	logic [PA_W-1:0] jj_q;
	logic [PA_W-1:0] ok_q;
	logic [PA_W-1:0] best_pos_q;
	logic [PE_W-1:0] best_q;
	logic [PE_W-1:0] ent_i_q;
	logic [PE_W-1:0] pk_rd;
	logic            pk_wr_en;
	logic [PA_W-1:0] pk_wr_addr;
	logic [PE_W-1:0] pk_wr_data;
	logic [PA_W-1:0] pk_rd_addr;
	logic            s_ld_s1;
	logic            s_cmp_s1;
	logic [PA_W-1:0] s_pos_s1;

	assign pk_wr_en = pk_keep || cmd.swap_a || cmd.swap_b;

	always_comb begin
		if (pk_keep) begin
			pk_wr_addr = count_q[PA_W-1:0];
			pk_wr_data = {p_idx_s1, here_q};
		end else if (cmd.swap_a) begin
			pk_wr_addr = si_q;
			pk_wr_data = best_q;
		end else begin
			pk_wr_addr = best_pos_q;
			pk_wr_data = ent_i_q;
		end
		if (cmd.sort_load) begin
			pk_rd_addr = si_q;
		end else if (cmd.sort_scan) begin
			pk_rd_addr = jj_q;
		end else begin
			pk_rd_addr = ok_q;
		end
	end

	sglms_ram #(
		.WIDTH (PE_W),
		.DEPTH (MAX_PEAKS)
	) u_peak_ram (
		.clk     (clk),
		.wr_en   (pk_wr_en),
		.wr_addr (pk_wr_addr),
		.wr_data (pk_wr_data),
		.rd_en   (cmd.sort_load || cmd.sort_scan || cmd.out_read),
		.rd_addr (pk_rd_addr),
		.rd_data (pk_rd)
	);

	assign sts.peak_none = (count_q == '0);
	assign sts.sort_more = (PK_W'(si_q) + PK_W'(1)) < count_q;
	assign sts.scan_last = (PK_W'(jj_q) + PK_W'(1)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			si_q     <= '0;
			jj_q     <= '0;
			ok_q     <= '0;
			s_ld_s1  <= 1'b0;
			s_cmp_s1 <= 1'b0;
		end else begin
			s_ld_s1  <= cmd.sort_load;
			s_cmp_s1 <= cmd.sort_scan;
			if (cmd.sort_start) begin
				si_q <= '0;
				ok_q <= '0;
			end else begin
				if (cmd.swap_b) begin
					si_q <= si_q + PA_W'(1);
				end
				if (cmd.out_next) begin
					ok_q <= ok_q + PA_W'(1);
				end
			end
			if (cmd.sort_load) begin
				jj_q <= si_q + PA_W'(1);
			end else if (cmd.sort_scan) begin
				jj_q <= jj_q + PA_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		s_pos_s1 <= jj_q;
		if (s_ld_s1) begin
			best_q     <= pk_rd;
			best_pos_q <= si_q;
			ent_i_q    <= pk_rd;
		end else if (s_cmp_s1 &&
			$signed(pk_rd[SCORE_BITS-1:0]) > $signed(best_q[SCORE_BITS-1:0])) begin
			best_q     <= pk_rd;
			best_pos_q <= s_pos_s1;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk) begin
		if (cmd.out_empty) begin
			out_index <= '0;
			out_score <= '0;
			out_none  <= 1'b1;
			out_final <= 1'b1;
		end else if (cmd.out_load) begin
			out_index <= sglms_pkg::OUT_INDEX_W'(pk_rd[PE_W-1:SCORE_BITS]);
			out_score <= sglms_pkg::OUT_SCORE_W'(pk_rd[SCORE_BITS-1:0]);
			out_none  <= 1'b0;
			out_final <= (PK_W'(ok_q) + PK_W'(1)) == count_q;
		end
	end

	assign sts.out_final = out_final;

endmodule

FILE: rtl/score_grid_local_maxima_sorter.sv
// Channel   Dir  Signals                         Contents
// -------   ---  ------------------------------  -------------------------------------------
// s_axis    in   s_tvalid s_tready s_tdata[31:0]  score, one grid entry per beat, row-major
// m_axis    out  m_tvalid m_tready m_tdata[39:0]  peak_index[7:0], peak_score[39:8]
//                m_tuser m_tlast                  tuser none_found, tlast is_last
// cfg       in   cfg_we cfg_index[1:0] cfg_data   0 half_span, 1 grid_mode, others ignored
//
// Load accepts one score per cycle while s_tready is high. The neighbour pass reads
// each entry and its N neighbours (N = 8 in grid mode, 2 in line mode) one by one,
// as the score memory has a single read port. P peaks are then sorted; each
// result is read from the peak list before it is offered and waits out any m_tready stall.
// No clearing pass after reset; the first beat can be taken right away.
// While results wait in the output register, scores of the next grid are taken,
// except the one that would complete it.
module score_grid_local_maxima_sorter #(
	parameter int MAX_HALF_SPAN = 7,
	parameter int SCORE_BITS    = 32,
	parameter int MAX_PEAKS     = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [sglms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sglms_pkg::CFG_DATA_W-1:0]    cfg_data,
	// score input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sglms_pkg::IN_W-1:0]          s_tdata,   // [31:0] score
	// peak output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sglms_pkg::OUT_DATA_W-1:0]    m_tdata,   // [7:0] peak_index, [39:8] peak_score
	output logic                                m_tuser,   // [0] none_found
	output logic                                m_tlast
);

	sglms_pkg::cmd_t cmd;
	sglms_pkg::sts_t sts;

	logic [sglms_pkg::OUT_INDEX_W-1:0] out_index;
	logic [sglms_pkg::OUT_SCORE_W-1:0] out_score;
	logic                              out_none;
	logic                              out_final;

	// sequencer: load, neighbour pass, sort, drain
	sglms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// config registers, score and peak memories, compare and output register
	sglms_dp #(
		.MAX_HALF_SPAN (MAX_HALF_SPAN),
		.SCORE_BITS    (SCORE_BITS),
		.MAX_PEAKS     (MAX_PEAKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_score  (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_index (out_index),
		.out_score (out_score),
		.out_none  (out_none),
		.out_final (out_final)
	);

	// beat layout: index in the low byte, score above
	assign m_tdata = {out_score, out_index};
	assign m_tuser = out_none;
	assign m_tlast = out_final;

endmodule

FILE: rtl/sglms_checker.sv
module sglms_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sglms_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                             m_tuser,
	input logic                             m_tlast
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("output beat changed under stall");

	// empty marker is a lone, zeroed, final beat
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("empty marker malformed");

	// after the final beat the block is back to loading
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("not ready to load after final beat");

	// next result needs a memory read first
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !m_tvalid)
		else $error("back-to-back results without fetch");

endmodule

bind score_grid_local_maxima_sorter sglms_checker u_sglms_checker (.*);

FILE: tb/peak_checker.sv
module peak_checker
	import sglms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,    // [31:0] score
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,    // [7:0] peak_index, [39:8] peak_score
	input  logic                  m_tuser,    // [0] none_found
	input  logic                  m_tlast,
	output int                    mismatch_count,
	output int                    peaks_pending
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPAN_LIMIT  = 7;
	localparam int PEAK_LIMIT  = 64;
	localparam int SIDE_LIMIT  = 2 * SPAN_LIMIT + 1;
	localparam int STORE_DEPTH = SIDE_LIMIT * SIDE_LIMIT;

	typedef struct packed {
		logic [OUT_INDEX_W-1:0] index;
		logic [OUT_SCORE_W-1:0] score;
		logic                   none_found;
		logic                   is_last;
	} peak_t;

	logic signed [IN_W-1:0] grid_scores [STORE_DEPTH];
	logic [2:0]             span_q;
	logic                   grid_q;
	int                     loaded;
	peak_t                  expected_peaks [$];

	// Strict 8- or 2-neighbour maxima over linear offsets, then selection sort
	// (first strict maximum wins, swapped into place).
	function automatic void predict_peaks(input int total, input int side, input logic grid);
		int    offs [8];
		int    found [PEAK_LIMIT];
		int    nbrs;
		int    count;
		int    nb;
		int    best;
		int    tmp;
		logic  keep;
		peak_t res;
		nbrs = 0;
		if (grid) begin
			for (int dy = -1; dy <= 1; dy++)
				for (int dx = -1; dx <= 1; dx++)
					if (dx != 0 || dy != 0) begin
						offs[nbrs] = dx + dy * side;
						nbrs++;
					end
		end else begin
			offs[0] = -1;
			offs[1] = 1;
			nbrs = 2;
		end
		count = 0;
		for (int i = 0; i < total; i++) begin
			keep = 1'b1;
			for (int k = 0; k < nbrs; k++) begin
				nb = i + offs[k];
				if (nb >= 0 && nb < total && grid_scores[nb] >= grid_scores[i])
					keep = 1'b0;
			end
			if (keep && count < PEAK_LIMIT) begin
				found[count] = i;
				count++;
			end
		end
		if (count == 0) begin
			res = '{index: '0, score: '0, none_found: 1'b1, is_last: 1'b1};
			expected_peaks.insert(expected_peaks.size(), res);
		end else begin
			for (int i = 0; i + 1 < count; i++) begin
				best = i;
				for (int j = i + 1; j < count; j++)
					if (grid_scores[found[j]] > grid_scores[found[best]])
						best = j;
				tmp = found[i];
				found[i] = found[best];
				found[best] = tmp;
			end
			for (int k = 0; k < count; k++) begin
				res.index      = OUT_INDEX_W'(found[k]);
				res.score      = grid_scores[found[k]];
				res.none_found = 1'b0;
				res.is_last    = (k == count - 1);
				expected_peaks.insert(expected_peaks.size(), res);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int    side;
		int    total;
		peak_t want;
		if (!arst_n) begin
			span_q = HALF_SPAN_RST;
			grid_q = GRID_MODE_RST;
			loaded = 0;
			mismatch_count = 0;
			expected_peaks.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_peaks.size() == 0) begin
					$error("unexpected peak beat: index %0d score %0d",
						m_tdata[OUT_INDEX_W-1:0], $signed(m_tdata[OUT_DATA_W-1:OUT_INDEX_W]));
					mismatch_count++;
				end else begin
					want = expected_peaks[0];
					expected_peaks.delete(0);
					if (m_tdata[OUT_INDEX_W-1:0] !== want.index) begin
						$error("peak_index mismatch: expected %0d, got %0d",
							want.index, m_tdata[OUT_INDEX_W-1:0]);
						mismatch_count++;
					end
					if (m_tdata[OUT_DATA_W-1:OUT_INDEX_W] !== want.score) begin
						$error("peak_score mismatch: expected %0d, got %0d", $signed(want.score),
							$signed(m_tdata[OUT_DATA_W-1:OUT_INDEX_W]));
						mismatch_count++;
					end
					if (m_tuser !== want.none_found) begin
						$error("none_found mismatch: expected %0b, got %0b",
							want.none_found, m_tuser);
						mismatch_count++;
					end
					if (m_tlast !== want.is_last) begin
						$error("is_last mismatch: expected %0b, got %0b", want.is_last, m_tlast);
						mismatch_count++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_HALF_SPAN) begin
					span_q = cfg_data[2:0];
					loaded = 0;
				end else if (cfg_index == REG_GRID_MODE) begin
					grid_q = cfg_data[0];
					loaded = 0;
				end
			end
			if (s_tvalid && s_tready) begin
				if (loaded < STORE_DEPTH)
					grid_scores[loaded] = s_tdata;
				loaded++;
				side  = 2 * ((span_q > SPAN_LIMIT) ? SPAN_LIMIT : span_q) + 1;
				total = grid_q ? side * side : side;
				if (loaded >= total) begin
					loaded = 0;
					predict_peaks(total, side, grid_q);
				end
			end
		end
		peaks_pending = expected_peaks.size();
	end

endmodule

FILE: tb/tb_top.sv
module tb_top;

	import sglms_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Scores are signed Q16.16
	localparam logic [IN_W-1:0] SCORE_MIN = 32'h8000_0000;
	localparam logic [IN_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;
	localparam logic [IN_W-1:0] SCORE_ONE = 32'h0001_0000;
	localparam logic [IN_W-1:0] SCORE_NEG = 32'hFFFF_FFFF;

	// Indexes the block must ignore
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// Random grids stop once this many scores have gone in; the full-size
	// grid at the end brings the run to at least 275 beats.
	localparam int ITEMS_BEFORE_LAST = 50;
	// Once the last peak is out the controller may still be stepping back to
	// idle; give it this many cycles before touching the registers.
	localparam int SETTLE_CYCLES  = 16;
	// Worst silent stretch is a full 15x15 pass plus sorting 64 peaks;
	// keep a wide margin over that.
	localparam int WATCHDOG_LIMIT = 20000;

	typedef enum int {
		STYLE_NOISE,   // full-range random words
		STYLE_LEVELS,  // few extreme levels: min, max, -1, 0, 1, one
		STYLE_FLAT,    // whole grid at one value, no maximum unless it has a single entry
		STYLE_TIES,    // small integers, lots of equal neighbours
		STYLE_PEAKS    // even row/even column entries dominate
	} score_style_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata   = '0;   // [31:0] score
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // [7:0] peak_index, [39:8] peak_score
	logic                  m_tuser;          // [0] none_found
	logic                  m_tlast;

	int mismatch_count;
	int peaks_pending;

	// Stimulus-side mirror of the register contents, used to size grids
	logic [2:0] cur_span = HALF_SPAN_RST;
	logic       cur_mode = GRID_MODE_RST;

	int   items_sent   = 0;
	logic calm         = 1'b0;   // no idling on either side
	logic gaps_on      = 1'b1;   // sender idles within the current grid
	int   ready_hold   = 0;
	int   stall_window = 0;
	logic stalls_on    = 1'b1;
	int   quiet_cycles = 0;

	always #5 clk = ~clk;

	score_grid_local_maxima_sorter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	peak_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.peaks_pending  (peaks_pending)
	);

	// Receiver back-pressure: random stall bursts, switched on and off
	// in windows so that long unstalled stretches occur as well.
	always @(negedge clk) begin
		if (stall_window == 0) begin
			stall_window = $urandom_range(20, 120);
			stalls_on = ($urandom_range(0, 2) != 0);
		end else
			stall_window--;
		if (calm || !stalls_on)
			m_tready <= 1'b1;
		else if (ready_hold != 0) begin
			m_tready <= 1'b0;
			ready_hold--;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			ready_hold = $urandom_range(0, 3);
		end else
			m_tready <= 1'b1;
	end

	// Watchdog: any beat on either stream restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// One score beat. Entered and left on a falling edge; tvalid stays high
	// afterwards so back-to-back beats need no extra edge.
	task automatic send_score(input logic [IN_W-1:0] value);
		if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	// Stop sending and wait for every predicted peak, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (peaks_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Single register write; we drops on the next cycle and the task waits with it low
	// so that consecutive writes give distinct pulses.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Only ever called with the block idle. Upper bits of the mode word are
	// random: the block must look at bit 0 alone.
	task automatic configure(input logic [2:0] span, input logic mode);
		logic [CFG_DATA_W-1:0] mode_word;
		drain();
		mode_word    = CFG_DATA_W'($urandom);
		mode_word[0] = mode;
		if ($urandom_range(0, 1) == 0) begin
			write_reg(REG_HALF_SPAN, span);
			write_reg(REG_GRID_MODE, mode_word);
		end else begin
			write_reg(REG_GRID_MODE, mode_word);
			write_reg(REG_HALF_SPAN, span);
		end
		cur_span = span;
		cur_mode = mode;
	endtask

	// Sends count scores of the given style in row-major order; a count below
	// the grid size leaves a partial load behind.
	task automatic send_grid(input score_style_t style, input int count);
		int              side;
		int              row;
		int              col;
		logic [IN_W-1:0] level;
		logic [IN_W-1:0] value;
		side    = 2 * cur_span + 1;
		level   = $urandom;
		gaps_on = ($urandom_range(0, 2) != 0);
		for (int n = 0; n < count; n++) begin
			row = n / side;
			col = n % side;
			case (style)
				STYLE_NOISE: value = $urandom;
				STYLE_LEVELS: begin
					case ($urandom_range(0, 5))
						0: value = SCORE_MIN;
						1: value = SCORE_MAX;
						2: value = SCORE_NEG;
						3: value = '0;
						4: value = 32'd1;
						default: value = SCORE_ONE;
					endcase
				end
				STYLE_FLAT: value = level;
				STYLE_TIES: value = IN_W'(($urandom_range(0, 3) - 1) * 65536);
				default: begin
					// non-negative on the even lattice, negative elsewhere; row-end
					// wrap still pits some lattice points against each other
					if (row % 2 == 0 && col % 2 == 0)
						value = {1'b0, 31'($urandom)};
					else
						value = {1'b1, 31'($urandom)};
				end
			endcase
			send_score(value);
		end
	endtask

	initial begin
		logic [2:0]   span;
		logic         mode;
		score_style_t style;
		int           side;
		int           total;
		logic         must_reconfigure;
		must_reconfigure = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed part ----
		// One-entry grids: no neighbour, the entry itself is the peak
		configure(3'd0, 1'b0);
		send_score(SCORE_MIN);
		send_score(SCORE_MAX);
		configure(3'd0, 1'b1);
		send_score('0);

		// Three-entry line: flat (nothing found), tied pair at both ends,
		// extremes with the maximum in the middle
		configure(3'd1, 1'b0);
		send_score(SCORE_ONE);
		send_score(SCORE_ONE);
		send_score(SCORE_ONE);
		send_score(3 * SCORE_ONE);
		send_score(32'd1);
		send_score(3 * SCORE_ONE);
		send_score(SCORE_MIN);
		send_score(SCORE_MAX);
		send_score(SCORE_NEG);

		// Writes to unused indexes must leave a partial load alone: the first score
		// after them completes the grid.
		send_score(SCORE_NEG);
		send_score(32'd1);
		drain();
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, '0);
		send_score(SCORE_ONE);

		// A real register write throws the partial load away
		send_score(SCORE_MAX);
		send_score(SCORE_MAX);
		configure(3'd1, 1'b0);
		send_score('0);
		send_score(SCORE_ONE);
		send_score('0);

		// 3x3 grid where the corner peaks meet across the row wrap
		configure(3'd1, 1'b1);
		send_score(9 * SCORE_ONE);
		send_score(SCORE_ONE);
		send_score(2 * SCORE_ONE);
		send_score(3 * SCORE_ONE);
		send_score(SCORE_ONE);
		send_score(4 * SCORE_ONE);
		send_score(SCORE_ONE);
		send_score(SCORE_ONE);
		send_score(8 * SCORE_ONE);

		// ---- random part: small grids, results overlap the next load ----
		while (items_sent < ITEMS_BEFORE_LAST) begin
			if (must_reconfigure || $urandom_range(0, 2) == 0) begin
				mode = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 7))
					0, 1: span = 3'd0;
					2, 3, 4: span = 3'd1;
					5, 6: span = 3'd2;
					default: span = mode ? 3'd2 : 3'($urandom_range(3, 7));
				endcase
				configure(span, mode);
				must_reconfigure = 1'b0;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: style = STYLE_NOISE;
				4, 5: style = STYLE_LEVELS;
				6: style = STYLE_FLAT;
				7, 8: style = STYLE_TIES;
				default: style = STYLE_PEAKS;
			endcase
			side  = 2 * cur_span + 1;
			total = cur_mode ? side * side : side;
			if (total > 1 && $urandom_range(0, 9) == 0) begin
				// broken load; the next register write must discard it
				send_grid(style, $urandom_range(1, total - 1));
				must_reconfigure = 1'b1;
			end else begin
				send_grid(style, total);
				if ($urandom_range(0, 7) == 0)
					drain();
			end
		end

		// ---- largest grid, full peak list, no idling from here on ----
		calm = 1'b1;
		configure(3'd7, 1'b1);
		send_grid(STYLE_PEAKS, 225);

		drain();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
